// ===== src/pwtrs_pkg.sv =====
// Shared constants, register codes and types for the PID unit with target ramp and slew limit.
`timescale 1ns / 1ps

package pwtrs_pkg;

	// ticks spent waiting between two ramp steps
	localparam int RAMP_INTERVAL = 10;
	localparam int TICK_W        = (RAMP_INTERVAL < 1) ? 1 : $clog2(RAMP_INTERVAL + 1);

	// request opcodes
	localparam logic [1:0] OP_KEEP = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_RAMP = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_I_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_I_WINDOW   = 3'd7;

	// configuration register file contents
	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [14:0]        integral_term_limit;
		logic [14:0]        output_limit;
		logic [15:0]        slew_step;
		logic [15:0]        ramp_step;
		logic [15:0]        integral_window;
	} cfg_t;

	// one tick's command to the target tracker
	typedef struct packed {
		logic               step;
		logic [1:0]         opcode;
		logic signed [15:0] new_target;
	} tgt_cmd_t;

endpackage

// ===== src/pid_with_target_ramp_and_slew_unit.sv =====
// Top level of the PID unit with target ramp, integral window and slew limit.
// Usage:
//   Input channel (in_valid / in_stall) carries one control tick per request:
//   opcode, new_target and measured. Output channel (out_valid / out_stall)
//   returns one request per tick: drive and ramping.
//   Configuration goes in through cfg_we / cfg_index / cfg_data; the user
//   writes it only while the unit is idle, which the unit does not enforce;
//   writes take effect on the next tick.
// Datapath: an accepted request waits in the input register and is computed
//   in a single pass into the drive / target state registers.
// Throughput: one request per cycle while out_stall is low; the single
//   registered pass through the integral multiply, sum clamps and slew
//   compare bounds the clock period.
// Reset: the tracker and PID state clears (target, ramp goal, error history,
//   error sum and last drive become zero), the configuration registers take
//   their reset values and both channels come up empty.
// Stall: while out_stall holds a pending result, the state does not move;
//   one further request can wait in the input register, after which in_stall
//   rises.
`timescale 1ns / 1ps

module pid_with_target_ramp_and_slew_unit import pwtrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic signed [15:0]   new_target,
	input  logic signed [15:0]   measured,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   drive,
	output logic                 ramping
);

	cfg_t               cfg;
	tgt_cmd_t           tgt_cmd;
	logic               valid_s1, out_valid_q, advance, accept;
	logic [1:0]         opcode_s1;
	logic signed [15:0] target_s1, measured_s1, target_next;

	// handshake control
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1   <= opcode;
			target_s1   <= new_target;
			measured_s1 <= measured;
		end
	end

	pwtrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign tgt_cmd.step       = advance;
	assign tgt_cmd.opcode     = opcode_s1;
	assign tgt_cmd.new_target = target_s1;

	pwtrs_target u_target (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (tgt_cmd),
		.ramp_step   (cfg.ramp_step),
		.target_next (target_next),
		.ramp_active (ramping)
	);

	pwtrs_pid u_pid (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.target   (target_next),
		.measured (measured_s1),
		.cfg      (cfg),
		.drive    (drive)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== src/pwtrs_cfg.sv =====
// Configuration register file of the PID unit.
`timescale 1ns / 1ps

module pwtrs_cfg import pwtrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes, indexed by position in the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p              <= '0;
			cfg_q.gain_i              <= '0;
			cfg_q.gain_d              <= '0;
			cfg_q.integral_term_limit <= 15'h7fff;
			cfg_q.output_limit        <= 15'h7fff;
			cfg_q.slew_step           <= 16'hffff;
			cfg_q.ramp_step           <= '0;
			cfg_q.integral_window     <= 16'hffff;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_P:    cfg_q.gain_p              <= $signed(cfg_data);
				CFG_GAIN_I:    cfg_q.gain_i              <= $signed(cfg_data);
				CFG_GAIN_D:    cfg_q.gain_d              <= $signed(cfg_data);
				CFG_I_LIMIT:   cfg_q.integral_term_limit <= cfg_data[14:0];
				CFG_OUT_LIMIT: cfg_q.output_limit        <= cfg_data[14:0];
				CFG_SLEW_STEP: cfg_q.slew_step           <= cfg_data;
				CFG_RAMP_STEP: cfg_q.ramp_step           <= cfg_data;
				CFG_I_WINDOW:  cfg_q.integral_window     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/pwtrs_target.sv =====
// Target tracker: opcode handling and stepped ramp toward the ramp goal.
`timescale 1ns / 1ps

module pwtrs_target import pwtrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tgt_cmd_t           cmd,
	input  logic [15:0]        ramp_step,
	output logic signed [15:0] target_next,
	output logic               ramp_active
);

	logic signed [15:0] target_q, goal_q;
	logic               active_q;
	logic [TICK_W-1:0]  tick_q;

	logic signed [15:0] tgt_a, goal_a, tgt_n;
	logic               act_a, act_n;
	logic [TICK_W-1:0]  tick_n;
	logic signed [17:0] tgt_ext, goal_ext, step_ext, up, dn;

	always_comb begin
		// opcode first
		tgt_a  = target_q;
		goal_a = goal_q;
		act_a  = active_q;
		case (cmd.opcode)
			OP_SET: tgt_a = cmd.new_target;
			OP_RAMP: begin
				if (goal_q != cmd.new_target) begin
					goal_a = cmd.new_target;
					act_a  = 1'b1;
				end
			end
			default: ;
		endcase

		// ramp step, landing on the goal once reached or passed
		tgt_ext  = 18'(tgt_a);
		goal_ext = 18'(goal_a);
		step_ext = $signed({2'b00, ramp_step});
		up       = tgt_ext + step_ext;
		dn       = tgt_ext - step_ext;
		tgt_n    = tgt_a;
		act_n    = act_a;
		tick_n   = tick_q;
		if (act_a) begin
			if (tick_q < TICK_W'(RAMP_INTERVAL)) begin
				tick_n = tick_q + 1'b1;
			end else begin
				tick_n = '0;
				if (tgt_a < goal_a) begin
					if (up >= goal_ext) begin
						tgt_n = goal_a;
						act_n = 1'b0;
					end else begin
						tgt_n = up[15:0];
					end
				end else if (tgt_a > goal_a) begin
					if (dn <= goal_ext) begin
						tgt_n = goal_a;
						act_n = 1'b0;
					end else begin
						tgt_n = dn[15:0];
					end
				end else begin
					act_n = 1'b0;
				end
			end
		end
	end

	// state update once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			goal_q   <= '0;
			active_q <= 1'b0;
			tick_q   <= '0;
		end else if (cmd.step) begin
			target_q <= tgt_n;
			goal_q   <= goal_a;
			active_q <= act_n;
			tick_q   <= tick_n;
		end
	end

	assign target_next = tgt_n;
	assign ramp_active = active_q;

endmodule

// ===== src/pwtrs_pid.sv =====
// PID datapath: error, P/I/D terms, integral window, clamps and slew limit.
`timescale 1ns / 1ps

module pwtrs_pid import pwtrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic signed [15:0] target,
	input  logic signed [15:0] measured,
	input  cfg_t               cfg,
	output logic signed [15:0] drive
);

	logic signed [16:0] err_q;
	logic signed [31:0] esum_q;
	logic signed [15:0] drive_q;

	logic signed [16:0] err;
	logic signed [17:0] derr, err18, win18;
	logic signed [32:0] p_prod, s33;
	logic signed [33:0] d_prod;
	logic signed [47:0] i_prod;
	logic signed [39:0] i_raw, ilim40;
	logic signed [15:0] i_term, sum16, drv;
	logic signed [31:0] esum_n;
	logic signed [27:0] sum28, olim28;
	logic signed [17:0] delta, slew18;
	logic               in_win;

	always_comb begin
		// error and its change since the last tick
		err   = 17'(target) - 17'(measured);
		derr  = 18'(err) - 18'(err_q);

		// products, floor division by 256 via dropping the low byte
		p_prod = cfg.gain_p * err;
		d_prod = cfg.gain_d * derr;

		// integral window test and saturating error sum
		err18  = 18'(err);
		win18  = $signed({2'b00, cfg.integral_window});
		in_win = (err18 < win18) && (err18 > -win18);
		s33    = 33'(esum_q) + 33'(err);
		if (s33[32] != s33[31])
			esum_n = s33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			esum_n = s33[31:0];

		// integral term and its clamp
		i_prod = cfg.gain_i * esum_n;
		i_raw  = i_prod[47:8];
		ilim40 = $signed({25'd0, cfg.integral_term_limit});
		if (i_raw > ilim40)
			i_term = ilim40[15:0];
		else if (i_raw < -ilim40)
			i_term = -ilim40[15:0];
		else
			i_term = i_raw[15:0];

		// summed output and its clamp
		sum28 = 28'($signed(p_prod[32:8])) + 28'($signed(d_prod[33:8]));
		if (in_win)
			sum28 = sum28 + 28'(i_term);
		olim28 = $signed({13'd0, cfg.output_limit});
		if (sum28 > olim28)
			sum16 = olim28[15:0];
		else if (sum28 < -olim28)
			sum16 = -olim28[15:0];
		else
			sum16 = sum28[15:0];

		// slew limit against the last drive
		delta  = 18'(sum16) - 18'(drive_q);
		slew18 = $signed({2'b00, cfg.slew_step});
		drv    = sum16;
		if (delta > slew18)
			drv = drive_q + cfg.slew_step;
		else if (delta < -slew18)
			drv = drive_q - cfg.slew_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= '0;
			esum_q  <= '0;
			drive_q <= '0;
		end else if (step) begin
			err_q   <= err;
			drive_q <= drv;
			if (in_win)
				esum_q <= esum_n;
		end
	end

	assign drive = drive_q;

endmodule

// ===== src/pwtrs_checker.sv =====
// Port-level checker for the PID unit, bound to the top level.
`timescale 1ns / 1ps

module pwtrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] drive,
	input logic               ramping
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(drive) && $stable(ramping))
		else $error("result payload changed while stalled");

	// back-pressure only comes from a stalled pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// an accepted request is followed by an offered result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted request produced no result");

endmodule

bind pid_with_target_ramp_and_slew_unit pwtrs_checker u_pwtrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive),
	.ramping   (ramping)
);
